// File: rtl/cpv_pkg.sv
// Package for the camera pose view matrix block: formats, mode codes, CORDIC table.
// No dependencies.
package cpv_pkg;
  localparam int POS_WIDTH_DEF  = 32;
  localparam int AXIS_WIDTH_DEF = 16;
  localparam int CORDIC_STEPS   = 16;
  localparam int MUL_W          = 18;

  localparam logic [2:0] MODE_MOVE_R = 3'd0;
  localparam logic [2:0] MODE_MOVE_U = 3'd1;
  localparam logic [2:0] MODE_MOVE_F = 3'd2;
  localparam logic [2:0] MODE_ROT_R  = 3'd3;
  localparam logic [2:0] MODE_ROT_U  = 3'd4;
  localparam logic [2:0] MODE_ROT_F  = 3'd5;

  localparam logic signed [35:0] DEG_TURN    = 36'sd23592960;
  localparam logic signed [35:0] DEG_HALF    = 36'sd11796480;
  localparam logic signed [35:0] DEG_QUARTER = 36'sd5898240;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

  function automatic logic signed [35:0] atan_deg(input logic [3:0] i);
    unique case (i)
      4'd0:  atan_deg = 36'sd2949120;
      4'd1:  atan_deg = 36'sd1740967;
      4'd2:  atan_deg = 36'sd919879;
      4'd3:  atan_deg = 36'sd466945;
      4'd4:  atan_deg = 36'sd234379;
      4'd5:  atan_deg = 36'sd117304;
      4'd6:  atan_deg = 36'sd58666;
      4'd7:  atan_deg = 36'sd29335;
      4'd8:  atan_deg = 36'sd14668;
      4'd9:  atan_deg = 36'sd7334;
      4'd10: atan_deg = 36'sd3667;
      4'd11: atan_deg = 36'sd1833;
      4'd12: atan_deg = 36'sd917;
      4'd13: atan_deg = 36'sd458;
      4'd14: atan_deg = 36'sd229;
      default: atan_deg = 36'sd115;
    endcase
  endfunction
endpackage

// File: rtl/cpv_serial_mul.sv
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add.
// Depends on cpv_pkg.
module cpv_serial_mul
  import cpv_pkg::*;
#(
  parameter int AW = 48,
  parameter int BW = 34
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic                    done,
  output logic signed [AW+BW-1:0] p
);
  localparam int CW = $clog2(BW + 1);
  logic signed [AW+BW-1:0] acc_r, acc_nxt, ash_r, ash_nxt;
  logic [BW-1:0]           b_r, b_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    ash_nxt  = ash_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      ash_nxt  = (AW+BW)'(a);
      b_nxt    = b;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // The top multiplier bit carries negative weight.
      if (b_r[0]) begin
        if (cnt_r == CW'(BW - 1)) acc_nxt = acc_r - ash_r;
        else                      acc_nxt = acc_r + ash_r;
      end
      ash_nxt = ash_r <<< 1;
      b_nxt   = b_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(BW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    ash_r <= ash_nxt;
    b_r   <= b_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign p    = acc_r;
endmodule

// File: rtl/cpv_cordic.sv
// Iterative rotation-mode CORDIC: sine and cosine of an angle in Q16.16 degrees.
// Depends on cpv_pkg.
module cpv_cordic
  import cpv_pkg::*;
#(
  parameter int AXIS_WIDTH = AXIS_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [31:0]           angle,
  output logic                         done,
  output logic signed [AXIS_WIDTH-1:0] cos_o,
  output logic signed [AXIS_WIDTH-1:0] sin_o
);
  localparam int FR  = AXIS_WIDTH - 2;
  localparam int SH  = 30 - FR;
  localparam int PH  = 0;
  logic signed [35:0] r_r, r_nxt;
  logic signed [33:0] x_r, x_nxt, y_r, y_nxt;
  logic [3:0]         i_r, i_nxt;
  logic [1:0]         ph_r, ph_nxt;
  logic               flip_r, flip_nxt, done_r, done_nxt;
  logic signed [35:0] red;
  logic signed [AXIS_WIDTH-1:0] xc, yc;

  // Round half up to the axis format and clamp to plus or minus one.
  function automatic logic signed [AXIS_WIDTH-1:0] sat1(input logic signed [33:0] v);
    logic signed [34:0] t;
    logic signed [34:0] one;
    t   = (35'(v) + (35'sd1 <<< (SH - 1))) >>> SH;
    one = 35'sd1 <<< FR;
    if (t > one)       sat1 = AXIS_WIDTH'(one);
    else if (t < -one) sat1 = AXIS_WIDTH'(-one);
    else               sat1 = AXIS_WIDTH'(t);
  endfunction

  always_comb begin
    r_nxt    = r_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    i_nxt    = i_r;
    ph_nxt   = ph_r;
    flip_nxt = flip_r;
    done_nxt = 1'b0;
    red      = r_r;
    unique case (ph_r)
      2'd0: begin
        if (start) begin
          r_nxt  = 36'(angle);
          ph_nxt = 2'd1;
        end
      end
      2'd1: begin
        // One conditional correction per cycle brings the angle into range.
        if (r_r < 0) r_nxt = r_r + DEG_TURN;
        else if (r_r >= DEG_TURN) r_nxt = r_r - DEG_TURN;
        else begin
          red = r_r;
          if (red > DEG_HALF) red = red - DEG_TURN;
          flip_nxt = 1'b0;
          if (red > DEG_QUARTER) begin
            red = red - DEG_HALF;
            flip_nxt = 1'b1;
          end else if (red < -DEG_QUARTER) begin
            red = red + DEG_HALF;
            flip_nxt = 1'b1;
          end
          r_nxt  = red;
          x_nxt  = CORDIC_START;
          y_nxt  = '0;
          i_nxt  = '0;
          ph_nxt = 2'd2;
        end
      end
      2'd2: begin
        if (r_r >= 0) begin
          x_nxt = x_r - (y_r >>> i_r);
          y_nxt = y_r + (x_r >>> i_r);
          r_nxt = r_r - atan_deg(i_r);
        end else begin
          x_nxt = x_r + (y_r >>> i_r);
          y_nxt = y_r - (x_r >>> i_r);
          r_nxt = r_r + atan_deg(i_r);
        end
        i_nxt = i_r + 1'b1;
        if (i_r == 4'(CORDIC_STEPS - 1)) ph_nxt = 2'd3;
      end
      default: begin
        ph_nxt   = 2'd0;
        done_nxt = 1'b1;
      end
    endcase
  end

  assign xc = sat1(x_r);
  assign yc = sat1(y_r);

  always_ff @(posedge clk) begin
    r_r    <= r_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    i_r    <= i_nxt;
    flip_r <= flip_nxt;
    if (ph_r == 2'd3) begin
      cos_o <= flip_r ? -xc : xc;
      sin_o <= flip_r ? -yc : yc;
    end
    if (!rst_n) begin
      ph_r   <= 2'(PH);
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
endmodule

// File: rtl/camera_pose_view_matrix.sv
// Top level of the camera pose view matrix block.
// Depends on cpv_pkg, cpv_serial_mul and cpv_cordic.
//
// Usage: each input beat on in_* carries a mode (tuser) and an amount (tdata).
// Modes 0..2 move the camera along its right, up or forward axis by a Q16.16
// distance; modes 3..5 rotate the other two axes about the chosen axis by
// amount degrees. Modes 6 and 7 leave the pose as it is.
// After every input beat the block sends exactly one output beat: the 3x4
// view matrix, axes as rows, with minus dot(axis, position) as translation.
// One item at a time goes through a single bit-serial multiplier. A move
// needs 3 products and a rotation 38, after a CORDIC pass; the translation
// column needs 9 more.
// Reset puts the camera at (0, 0, 10) looking down minus z, with right = x
// and up = y. The result waits in an output register while out_tready is
// low; a new input beat is taken only after the result has been taken.
module camera_pose_view_matrix
  import cpv_pkg::*;
#(
  parameter int POS_WIDTH  = POS_WIDTH_DEF,
  parameter int AXIS_WIDTH = AXIS_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // amount [31:0]
  input  logic [2:0]   in_tuser,   // mode [2:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  // right_x, right_y, right_z, right_shift, up_x, up_y, up_z, up_shift,
  // fwd_x, fwd_y, fwd_z, fwd_shift, from the lowest bit up
  output logic [9*AXIS_WIDTH+96+((8-((9*AXIS_WIDTH+96)%8))%8)-1:0] out_tdata
);
  localparam int PF  = POS_WIDTH - 16;
  localparam int AF  = AXIS_WIDTH - 2;
  localparam int AW  = 48;
  localparam int BW  = (POS_WIDTH > 32) ? POS_WIDTH : 34;
  localparam int PW  = AW + BW;
  localparam int OW  = 9*AXIS_WIDTH + 96;
  localparam int PADW = (8 - (OW % 8)) % 8;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MOVE   = 4'd1;
  localparam logic [3:0] S_MOVEW  = 4'd2;
  localparam logic [3:0] S_CORD   = 4'd3;
  localparam logic [3:0] S_CORDW  = 4'd4;
  localparam logic [3:0] S_ROT    = 4'd5;
  localparam logic [3:0] S_ROTW   = 4'd6;
  localparam logic [3:0] S_SHIFT  = 4'd7;
  localparam logic [3:0] S_SHIFTW = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] st_r, st_nxt;
  logic signed [POS_WIDTH-1:0]  pos_r [3];
  logic signed [AXIS_WIDTH-1:0] ax_r  [3][3];   // [axis][component]
  logic signed [AXIS_WIDTH-1:0] nv_r  [2][3];   // turned vectors
  logic [2:0]  mode_r;
  logic signed [31:0] amt_r;
  logic [5:0]  step_r;
  logic signed [PW-1:0] acc_r;
  logic signed [AXIS_WIDTH-1:0] cos_r, sin_r;
  logic signed [AXIS_WIDTH+1:0] cr_r [3];
  logic signed [AXIS_WIDTH+1:0] d_r, t_r;
  logic signed [31:0] sh_r [3];
  logic [OW+PADW-1:0] out_r;
  logic out_v_r;

  logic mstart, mdone;
  logic signed [AW-1:0] ma;
  logic signed [BW-1:0] mb;
  logic signed [PW-1:0] mp;
  logic cstart, cdone;
  logic signed [AXIS_WIDTH-1:0] cc, cs;

  cpv_serial_mul #(.AW(AW), .BW(BW)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mstart), .a(ma), .b(mb), .done(mdone), .p(mp)
  );
  cpv_cordic #(.AXIS_WIDTH(AXIS_WIDTH)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cstart), .angle(amt_r),
    .done(cdone), .cos_o(cc), .sin_o(cs)
  );

  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v,
                                              input int s);
    rnd = (s <= 0) ? (v <<< (-s)) : ((v + (PW'(1) <<< (s - 1))) >>> s);
  endfunction

  function automatic logic signed [AXIS_WIDTH-1:0] sat_axis(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] one;
    one = PW'(1) <<< AF;
    if (v > one)       sat_axis = AXIS_WIDTH'(one);
    else if (v < -one) sat_axis = AXIS_WIDTH'(-one);
    else               sat_axis = AXIS_WIDTH'(v);
  endfunction

  function automatic logic signed [PW-1:0] sat_lim(input logic signed [PW-1:0] v,
                                                  input int w);
    logic signed [PW-1:0] hi;
    hi = (PW'(1) <<< (w - 1)) - 1;
    if (v > hi)          sat_lim = hi;
    else if (v < -hi - 1) sat_lim = -hi - 1;
    else                 sat_lim = v;
  endfunction

  // Rotation pivot index and the two turned axes.
  logic [1:0] kx, v0x, v1x;
  always_comb begin
    unique case (mode_r)
      MODE_ROT_R: begin kx = 2'd0; v0x = 2'd1; v1x = 2'd2; end
      MODE_ROT_U: begin kx = 2'd1; v0x = 2'd0; v1x = 2'd2; end
      default:    begin kx = 2'd2; v0x = 2'd0; v1x = 2'd1; end
    endcase
  end

  // Rotation sub-step plan per turned vector (19 products):
  // 0..5 cross terms, 6..8 dot, 9 t, 10..18 v*c + cr*s + k*t, three per component.
  logic       vsel;
  logic [4:0] sub;
  logic [1:0] ci;
  logic [1:0] rs;
  assign vsel = (step_r >= 6'd19);
  assign sub  = vsel ? 5'(step_r - 6'd19) : step_r[4:0];

  // Component and term of the current output product.
  always_comb begin
    ci = 2'd0;
    rs = 2'd0;
    unique case (sub)
      5'd13, 5'd14, 5'd15: ci = 2'd1;
      5'd16, 5'd17, 5'd18: ci = 2'd2;
      default: ;
    endcase
    unique case (sub)
      5'd11, 5'd14, 5'd17: rs = 2'd1;
      5'd12, 5'd15, 5'd18: rs = 2'd2;
      default: ;
    endcase
  end

  logic signed [AXIS_WIDTH-1:0] kv [3];
  logic signed [AXIS_WIDTH-1:0] vv [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      kv[j] = ax_r[kx][j];
      vv[j] = vsel ? ax_r[v1x][j] : ax_r[v0x][j];
    end
  end

  logic signed [POS_WIDTH+1:0] pr [3];
  always_comb begin
    for (int j = 0; j < 3; j++)
      pr[j] = (POS_WIDTH+2)'(sat_lim(rnd(PW'(pos_r[j]), PF - 16), 32));
  end

  // Operand select for the multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (st_r)
      S_MOVE: begin
        ma = AW'(amt_r);
        mb = BW'(ax_r[mode_r[1:0]][step_r[1:0]]);
      end
      S_ROT: begin
        unique case (sub)
          5'd0: begin ma = AW'(kv[1]); mb = BW'(vv[2]); end
          5'd1: begin ma = AW'(kv[2]); mb = BW'(vv[1]); end
          5'd2: begin ma = AW'(kv[2]); mb = BW'(vv[0]); end
          5'd3: begin ma = AW'(kv[0]); mb = BW'(vv[2]); end
          5'd4: begin ma = AW'(kv[0]); mb = BW'(vv[1]); end
          5'd5: begin ma = AW'(kv[1]); mb = BW'(vv[0]); end
          5'd6: begin ma = AW'(kv[0]); mb = BW'(vv[0]); end
          5'd7: begin ma = AW'(kv[1]); mb = BW'(vv[1]); end
          5'd8: begin ma = AW'(kv[2]); mb = BW'(vv[2]); end
          5'd9: begin
            ma = AW'(d_r);
            mb = BW'((AXIS_WIDTH+2)'(1 <<< AF) - (AXIS_WIDTH+2)'(cos_r));
          end
          default: begin
            unique case (rs)
              2'd0:    begin ma = AW'(vv[ci]); mb = BW'(cos_r); end
              2'd1:    begin ma = AW'(cr_r[ci]); mb = BW'(sin_r); end
              default: begin ma = AW'(kv[ci]); mb = BW'(t_r); end
            endcase
          end
        endcase
      end
      S_SHIFT: begin
        ma = AW'(ax_r[step_r[3:2]][step_r[1:0]]);
        mb = BW'(pr[step_r[1:0]]);
      end
      default: ;
    endcase
  end

  assign mstart = (st_r == S_MOVE) || (st_r == S_ROT) || (st_r == S_SHIFT);
  assign cstart = (st_r == S_CORD);
  assign in_tready = (st_r == S_IDLE) && !out_v_r;

  logic signed [PW-1:0] sum;
  assign sum = acc_r + mp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      out_v_r <= 1'b0;
      pos_r[0] <= '0;
      pos_r[1] <= '0;
      pos_r[2] <= POS_WIDTH'(10) <<< PF;
      for (int a = 0; a < 3; a++)
        for (int j = 0; j < 3; j++)
          if (a != j)      ax_r[a][j] <= '0;
          else if (a == 2) ax_r[a][j] <= -(AXIS_WIDTH'(1) <<< AF);
          else             ax_r[a][j] <= AXIS_WIDTH'(1) <<< AF;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            mode_r <= in_tuser;
            amt_r  <= in_tdata;
            step_r <= '0;
            acc_r  <= '0;
            if (in_tuser <= MODE_MOVE_F)     st_r <= S_MOVE;
            else if (in_tuser <= MODE_ROT_F) st_r <= S_CORD;
            else                             st_r <= S_SHIFT;
          end
        end
        S_MOVE: st_r <= S_MOVEW;
        S_MOVEW: begin
          if (mdone) begin
            pos_r[step_r[1:0]] <= POS_WIDTH'(sat_lim(PW'(pos_r[step_r[1:0]])
                                  + rnd(mp, 16 + AF - PF), POS_WIDTH));
            if (step_r == 6'd2) begin
              step_r <= '0;
              st_r   <= S_SHIFT;
            end else begin
              step_r <= step_r + 1'b1;
              st_r   <= S_MOVE;
            end
          end
        end
        S_CORD: st_r <= S_CORDW;
        S_CORDW: begin
          if (cdone) begin
            cos_r <= cc;
            sin_r <= cs;
            st_r  <= S_ROT;
          end
        end
        S_ROT: st_r <= S_ROTW;
        S_ROTW: begin
          if (mdone) begin
            if (sub <= 5'd5) begin
              if (sub[0] == 1'b0) acc_r <= mp;
              else begin
                cr_r[sub[2:1]] <= (AXIS_WIDTH+2)'(rnd(acc_r - mp, AF));
                acc_r <= '0;
              end
            end else if (sub <= 5'd8) begin
              if (sub == 5'd8) begin
                d_r   <= (AXIS_WIDTH+2)'(rnd(sum, AF));
                acc_r <= '0;
              end else acc_r <= sum;
            end else if (sub == 5'd9) begin
              t_r   <= (AXIS_WIDTH+2)'(rnd(mp, AF));
              acc_r <= '0;
            end else if (rs == 2'd2) begin
              nv_r[vsel][ci] <= sat_axis(rnd(sum, AF));
              acc_r <= '0;
            end else begin
              acc_r <= sum;
            end
            if (step_r == 6'd37) begin
              // The last component of the second vector is taken straight from the sum.
              for (int j = 0; j < 3; j++) begin
                ax_r[v0x][j] <= nv_r[0][j];
                ax_r[v1x][j] <= (j == 2) ? sat_axis(rnd(sum, AF)) : nv_r[1][j];
              end
              step_r <= '0;
              st_r   <= S_SHIFT;
            end else begin
              step_r <= step_r + 1'b1;
              st_r   <= S_ROT;
            end
          end
        end
        S_SHIFT: st_r <= S_SHIFTW;
        S_SHIFTW: begin
          if (mdone) begin
            // step_r[3:2] is the row, step_r[1:0] the component.
            if (step_r[1:0] == 2'd2) begin
              sh_r[step_r[3:2]] <= 32'(sat_lim(rnd(-sum, AF), 32));
              acc_r <= '0;
              if (step_r[3:2] == 2'd2) st_r <= S_OUT;
              else begin
                step_r <= {step_r[5:4], step_r[3:2] + 2'd1, 2'd0};
                st_r   <= S_SHIFT;
              end
            end else begin
              acc_r  <= sum;
              step_r <= step_r + 1'b1;
              st_r   <= S_SHIFT;
            end
          end
        end
        default: begin
          if (!out_v_r) begin
            out_r <= (OW+PADW)'({sh_r[2], ax_r[2][2], ax_r[2][1], ax_r[2][0],
                                 sh_r[1], ax_r[1][2], ax_r[1][1], ax_r[1][0],
                                 sh_r[0], ax_r[0][2], ax_r[0][1], ax_r[0][0]});
            out_v_r <= 1'b1;
            st_r    <= S_IDLE;
          end
        end
      endcase
      if (out_v_r && out_tready) out_v_r <= 1'b0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;
endmodule

// File: rtl/cpv_checker.sv
// Port-level checker for camera_pose_view_matrix, bound to the top level.
// Depends on camera_pose_view_matrix.
module cpv_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready
);
  // One item at a time: input is not taken while a result waits.
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input ready while result pending");
  // An accepted item cannot produce a result in the next cycle.
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !out_tvalid) else $error("result too early");
  // A stalled result stays valid.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("result dropped");
endmodule

bind camera_pose_view_matrix cpv_checker u_cpv_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready)
);
